[sv/tld_pkg.sv]
// ============================================================================
// tld_pkg - shared types and constants for the trace loop detector
// Field widths, saturation limits and the divider request/response types.
// ============================================================================
`default_nettype none

package tld_pkg;

    // address item: segment in the upper half, offset in the lower half
    localparam int SEG_W         = 16;
    localparam int ADDR_W        = 2 * SEG_W;

    // run counter and reported period
    localparam int RUN_W         = 24;
    localparam int PERIOD_W      = 8;

    // default history depth
    localparam int DEPTH_DEFAULT = 512;

    // saturation limits and iteration bias
    localparam logic [RUN_W-1:0]    RUN_MAX    = {RUN_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
    localparam logic [RUN_W-1:0]    ITER_BIAS  = RUN_W'(2);

    // divider step counter width (counts RUN_W steps down to one)
    localparam int DIV_CNT_W     = $clog2(RUN_W + 1);

    // divider request
    typedef struct packed {
        logic                start;
        logic [RUN_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    // divider response
    typedef struct packed {
        logic             busy;
        logic [RUN_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

[sv/tld_cell.sv]
// ============================================================================
// tld_cell - one period cell of the detector chain
// Holds the address seen PERIOD items ago and a count of consecutive items
// that equalled it; flags a full period repeat.
// ============================================================================
`default_nettype none

module tld_cell #(
    parameter int CNT_W   = 8,
    parameter int CNT_CAP = 255,
    parameter int PERIOD  = 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      shift_en,
    input  wire logic [tld_pkg::ADDR_W-1:0] item_word,
    input  wire logic [tld_pkg::ADDR_W-1:0] tap_in,
    output logic      [tld_pkg::ADDR_W-1:0] tap_out,
    output logic                           match
);

    logic [tld_pkg::ADDR_W-1:0] tap_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       match_reg;

    // run of equal compares, saturating; reset history is all zeros so the
    // count starts full
    always_comb
    begin
        if (item_word == tap_reg)
        begin
            if (cnt_reg == CNT_W'(CNT_CAP))
                cnt_next = cnt_reg;
            else
                cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = '0;
        end
    end

    // shift tap along, update count and repeat flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg   <= '0;
            cnt_reg   <= CNT_W'(CNT_CAP);
            match_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            tap_reg   <= tap_in;
            cnt_reg   <= cnt_next;
            match_reg <= (cnt_next >= CNT_W'(PERIOD));
        end
    end

    assign tap_out = tap_reg;
    assign match   = match_reg;

endmodule

`default_nettype wire

[sv/tld_first.sv]
// ============================================================================
// tld_first - registered priority tree
// Finds the lowest flagged leaf; every tree level is registered.
// ============================================================================
`default_nettype none

module tld_first #(
    parameter int IDX_W = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic [(1<<IDX_W)-1:0]   leaf_found,
    output logic                         found,
    output logic      [IDX_W-1:0]        idx
);

    localparam int LEAVES = 1 << IDX_W;

    // heap layout: node i has children 2i and 2i+1, root is node 1
    logic             node_found_reg [1:LEAVES-1];
    logic [IDX_W-1:0] node_idx_reg   [1:LEAVES-1];

    for (genvar i = 1; i < LEAVES; i++)
    begin : g_node
        logic             lf;
        logic             rf;
        logic [IDX_W-1:0] li;
        logic [IDX_W-1:0] ri;

        if (2 * i >= LEAVES)
        begin : g_bottom
            assign lf = leaf_found[2*i-LEAVES];
            assign rf = leaf_found[2*i+1-LEAVES];
            assign li = IDX_W'(2*i-LEAVES);
            assign ri = IDX_W'(2*i+1-LEAVES);
        end
        else
        begin : g_inner
            assign lf = node_found_reg[2*i];
            assign rf = node_found_reg[2*i+1];
            assign li = node_idx_reg[2*i];
            assign ri = node_idx_reg[2*i+1];
        end

        // lower index wins
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                node_found_reg[i] <= 1'b0;
            else if (en)
                node_found_reg[i] <= lf | rf;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                node_idx_reg[i] <= lf ? li : ri;
        end
    end

    assign found = node_found_reg[1];
    assign idx   = node_idx_reg[1];

endmodule

`default_nettype wire

[sv/tld_divider.sv]
// ============================================================================
// tld_divider - iterative restoring divider
// Run count over period, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module tld_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tld_pkg::div_req_t req,
    output tld_pkg::div_rsp_t      rsp
);

    localparam int RW = tld_pkg::RUN_W;
    localparam int PW = tld_pkg::PERIOD_W;

    logic                          busy_reg;
    logic [tld_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [RW-1:0]                 quo_reg;
    logic [PW-1:0]                 rem_reg;
    logic [PW-1:0]                 dvs_reg;

    logic [PW:0]   trial;
    logic [PW:0]   diff;
    logic          ge;
    logic [PW-1:0] rem_step;
    logic [RW-1:0] quo_step;

    // one restoring step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[RW-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_step = ge ? diff[PW-1:0] : trial[PW-1:0];
        quo_step = {quo_reg[RW-2:0], ge};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= tld_pkg::DIV_CNT_W'(RW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == tld_pkg::DIV_CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[sv/trace_loop_detector.sv]
// ============================================================================
// trace_loop_detector - repeating-period detector for an instruction trace
// Flags items that complete a repeat of the shortest period and reports
// period and iteration count when a loop run ends.
// ============================================================================
//
//  channel  handshake                  payload
//  -------  -------------------------  -------------------------------------
//  item     item_valid / item_stall    code_segment, instr_offset
//  result   result_valid / result_stall in_loop, loop_ended, report_period,
//                                      report_iterations
//
//  One item per cycle while item_stall is low; the path runs through the cell
//  compare on the accepting edge, one register per priority tree level and the
//  output register.
//  A loop end holds item intake while the divider produces one quotient bit
//  per cycle.
//  Reset is asynchronous; cells start with zero addresses and full counts.
//  result_stall freezes the pipeline while a result is held; item_stall follows it
//
`default_nettype none

module trace_loop_detector #(
    parameter int HISTORY_DEPTH = tld_pkg::DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [tld_pkg::SEG_W-1:0]      code_segment,
    input  wire logic [tld_pkg::SEG_W-1:0]      instr_offset,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic                                in_loop,
    output logic                                loop_ended,
    output logic      [tld_pkg::PERIOD_W-1:0]   report_period,
    output logic      [tld_pkg::RUN_W-1:0]      report_iterations
);

    localparam int NUM_PERIODS = HISTORY_DEPTH / 2 - 1;
    localparam int IDX_W       = $clog2(HISTORY_DEPTH / 2);
    localparam int LEAVES      = 1 << IDX_W;
    localparam int RW          = tld_pkg::RUN_W;
    localparam int PW          = tld_pkg::PERIOD_W;
    localparam int EXT_W       = (IDX_W > PW) ? IDX_W : PW;

    // iteration count plus bias, saturating
    function automatic logic [RW-1:0] add_bias(input logic [RW-1:0] q);
        logic [RW:0] sum;
        sum = {1'b0, q} + {1'b0, tld_pkg::ITER_BIAS};
        return sum[RW] ? tld_pkg::RUN_MAX : sum[RW-1:0];
    endfunction

    logic                          en;
    logic                          out_free;
    logic                          accept;
    logic [tld_pkg::ADDR_W-1:0]    tap [0:NUM_PERIODS];
    logic [LEAVES-1:0]             leaf_found;
    logic [IDX_W:0]                v_reg;
    logic                          root_found;
    logic [IDX_W-1:0]              root_idx;
    logic [EXT_W-1:0]              idx_ext;
    logic [PW-1:0]                 period_sat;

    logic [RW-1:0] run_cnt_reg, run_cnt_next;
    logic [PW-1:0] last_period_reg, last_period_next;
    logic          tail_busy_reg, tail_busy_next;
    logic          out_valid_reg, out_valid_next;
    logic          in_loop_reg, in_loop_next;
    logic          ended_reg, ended_next;
    logic [PW-1:0] period_reg, period_next;
    logic [RW-1:0] iter_reg, iter_next;

    logic              take;
    logic              finish;
    tld_pkg::div_req_t div_req;
    tld_pkg::div_rsp_t div_rsp;

    // global advance
    assign out_free   = !out_valid_reg || !result_stall;
    assign en         = !tail_busy_reg && out_free;
    assign item_stall = !en;
    assign accept     = item_valid && en;

    // cell chain: tap k holds the address k items back
    assign tap[0] = {code_segment, instr_offset};

    for (genvar j = 0; j < LEAVES; j++)
    begin : g_leaf
        if (j >= 1 && j <= NUM_PERIODS)
        begin : g_cell
            tld_cell #(
                .CNT_W   (IDX_W),
                .CNT_CAP (NUM_PERIODS),
                .PERIOD  (j)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (accept),
                .item_word (tap[0]),
                .tap_in    (tap[j-1]),
                .tap_out   (tap[j]),
                .match     (leaf_found[j])
            );
        end
        else
        begin : g_pad
            assign leaf_found[j] = 1'b0;
        end
    end

    // shortest matching period
    tld_first #(
        .IDX_W (IDX_W)
    ) u_first (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .leaf_found (leaf_found),
        .found      (root_found),
        .idx        (root_idx)
    );

    // item valid along cell and tree stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[IDX_W-1:0], item_valid};
    end

    // period clipped to the report width
    assign idx_ext    = EXT_W'(root_idx);
    assign period_sat = (idx_ext > EXT_W'(tld_pkg::PERIOD_MAX)) ? tld_pkg::PERIOD_MAX
                                                               : idx_ext[PW-1:0];

    assign take   = en && v_reg[IDX_W];
    assign finish = tail_busy_reg && !div_rsp.busy && out_free;

    // divider kick on a loop end
    assign div_req.start    = take && !root_found && (run_cnt_reg != '0)
                              && (last_period_reg != '0);
    assign div_req.dividend = run_cnt_reg;
    assign div_req.divisor  = last_period_reg;

    tld_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // run tracking and result formation
    always_comb
    begin
        run_cnt_next     = run_cnt_reg;
        last_period_next = last_period_reg;
        tail_busy_next   = tail_busy_reg;
        out_valid_next   = out_valid_reg && result_stall;
        in_loop_next     = in_loop_reg;
        ended_next       = ended_reg;
        period_next      = period_reg;
        iter_next        = iter_reg;

        if (finish)
        begin
            tail_busy_next = 1'b0;
            out_valid_next = 1'b1;
            in_loop_next   = 1'b0;
            ended_next     = 1'b1;
            period_next    = last_period_reg;
            iter_next      = add_bias(div_rsp.quotient);
        end

        if (take)
        begin
            if (root_found)
            begin
                last_period_next = period_sat;
                if (run_cnt_reg != tld_pkg::RUN_MAX)
                    run_cnt_next = run_cnt_reg + 1'b1;
                out_valid_next = 1'b1;
                in_loop_next   = 1'b1;
                ended_next     = 1'b0;
                period_next    = '0;
                iter_next      = '0;
            end
            else if (run_cnt_reg != '0)
            begin
                run_cnt_next = '0;
                if (last_period_reg == '0)
                begin
                    // no period recorded: run count reported undivided, plus the bias
                    out_valid_next = 1'b1;
                    in_loop_next   = 1'b0;
                    ended_next     = 1'b1;
                    period_next    = last_period_reg;
                    iter_next      = add_bias(run_cnt_reg);
                end
                else
                begin
                    tail_busy_next = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b1;
                in_loop_next   = 1'b0;
                ended_next     = 1'b0;
                period_next    = '0;
                iter_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg     <= '0;
            last_period_reg <= '0;
            tail_busy_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            in_loop_reg     <= 1'b0;
            ended_reg       <= 1'b0;
            period_reg      <= '0;
            iter_reg        <= '0;
        end
        else
        begin
            run_cnt_reg     <= run_cnt_next;
            last_period_reg <= last_period_next;
            tail_busy_reg   <= tail_busy_next;
            out_valid_reg   <= out_valid_next;
            in_loop_reg     <= in_loop_next;
            ended_reg       <= ended_next;
            period_reg      <= period_next;
            iter_reg        <= iter_next;
        end
    end

    assign result_valid      = out_valid_reg;
    assign in_loop           = in_loop_reg;
    assign loop_ended        = ended_reg;
    assign report_period     = period_reg;
    assign report_iterations = iter_reg;

`ifndef SYNTHESIS
    // no intake while a loop report is being divided out
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        tail_busy_reg |-> item_stall)
        else $error("item intake while divider report pending");

    // a result is never both a loop item and a loop end
    a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(in_loop && loop_ended))
        else $error("in_loop and loop_ended together");

    // report fields are zero unless a loop has ended
    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !loop_ended) |-> (report_period == '0 && report_iterations == '0))
        else $error("report fields set without loop end");

    // a divider report starts only from a live run, which is then cleared
    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tail_busy_reg) |-> (run_cnt_reg == '0 && $past(run_cnt_reg) != '0))
        else $error("loop end report without a cleared run");
`endif

endmodule

`default_nettype wire

[sim/trace_loop_detector_tb.sv]
// ============================================================================
// trace_loop_detector_tb - self-checking bench for the trace loop detector
// Feeds instruction addresses through the item channel: a short directed
// opening, then repeating patterns, near-miss patterns and noise. A
// scoreboard keeps its own copy of the address history, works out the
// shortest repeating period for every accepted item and checks each result
// in order. The item channel idles and the result channel stalls in random bursts.
// ============================================================================
`timescale 1ns / 1ps

module trace_loop_detector_tb;

    // one expected result item
    typedef struct packed {
        logic                         in_loop;
        logic                         loop_ended;
        logic [tld_pkg::PERIOD_W-1:0] period;
        logic [tld_pkg::RUN_W-1:0]    iterations;
    } loop_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: address history, period search and run bookkeeping
    // ------------------------------------------------------------------------
    class period_scoreboard;
        localparam int DEPTH = tld_pkg::DEPTH_DEFAULT;

        logic [tld_pkg::ADDR_W-1:0]   history [DEPTH];
        int unsigned                  wr_slot;
        logic [tld_pkg::RUN_W-1:0]    run_count;
        logic [tld_pkg::PERIOD_W-1:0] period_seen;
        loop_result_t                 pending_results [$];
        int unsigned                  failures;

        function new();
            foreach (history[i])
                history[i] = '0;
            wr_slot     = 0;
            run_count   = '0;
            period_seen = '0;
            failures    = 0;
        endfunction

        // slot lying back entries behind the newest one
        function int unsigned slot_back(int unsigned back);
            return (wr_slot + 2 * DEPTH - 1 - back) % DEPTH;
        endfunction

        // last n addresses equal the n addresses before them
        function bit repeats_every(int unsigned n);
            for (int unsigned p = 0; p < n; p++)
                if (history[slot_back(p)] !== history[slot_back(p + n)])
                    return 1'b0;
            return 1'b1;
        endfunction

        // accepted input item: store it and work out its result
        function void note_item(logic [tld_pkg::SEG_W-1:0] seg,
                                logic [tld_pkg::SEG_W-1:0] off);
            loop_result_t res;
            int unsigned  laps;
            res = '0;
            history[wr_slot] = {seg, off};
            wr_slot = (wr_slot + 1) % DEPTH;

            // shortest period wins; report fields stay zero while looping
            for (int unsigned n = 1; n < DEPTH / 2; n++)
            begin
                if (repeats_every(n))
                begin
                    period_seen = (n > tld_pkg::PERIOD_MAX) ? tld_pkg::PERIOD_MAX
                                                            : tld_pkg::PERIOD_W'(n);
                    if (run_count != tld_pkg::RUN_MAX)
                        run_count++;
                    res.in_loop = 1'b1;
                    pending_results.push_back(res);
                    return;
                end
            end

            // run just ended: report period and saturated iteration count
            if (run_count != 0)
            begin
                laps = (period_seen != 0) ? run_count / period_seen : run_count;
                laps += tld_pkg::ITER_BIAS;
                if (laps > tld_pkg::RUN_MAX)
                    laps = tld_pkg::RUN_MAX;
                res.loop_ended = 1'b1;
                res.period     = period_seen;
                res.iterations = laps[tld_pkg::RUN_W-1:0];
                run_count      = '0;
            end
            pending_results.push_back(res);
        endfunction

        // accepted result item: compare with the oldest expectation
        function void check_result(logic il, logic le, logic [tld_pkg::PERIOD_W-1:0] rp,
                                   logic [tld_pkg::RUN_W-1:0] ri);
            loop_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: in_loop=%0d loop_ended=%0d", il, le);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (il !== want.in_loop)
            begin
                $error("in_loop: expected %0d, got %0d", want.in_loop, il);
                failures++;
            end
            if (le !== want.loop_ended)
            begin
                $error("loop_ended: expected %0d, got %0d", want.loop_ended, le);
                failures++;
            end
            if (rp !== want.period)
            begin
                $error("report_period: expected %0d, got %0d", want.period, rp);
                failures++;
            end
            if (ri !== want.iterations)
            begin
                $error("report_iterations: expected %0d, got %0d", want.iterations, ri);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, ports and the block
    // ------------------------------------------------------------------------
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    logic                         item_stall;
    logic [tld_pkg::SEG_W-1:0]    code_segment = '0;
    logic [tld_pkg::SEG_W-1:0]    instr_offset = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic                         in_loop;
    logic                         loop_ended;
    logic [tld_pkg::PERIOD_W-1:0] report_period;
    logic [tld_pkg::RUN_W-1:0]    report_iterations;

    period_scoreboard    sb = new();
    int unsigned         items_sent = 0;
    int unsigned         hold_left = 0;
    bit                  calm_tail = 1'b0;

    always #5 clk = ~clk;

    trace_loop_detector u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .code_segment      (code_segment),
        .instr_offset      (instr_offset),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .in_loop           (in_loop),
        .loop_ended        (loop_ended),
        .report_period     (report_period),
        .report_iterations (report_iterations)
    );

    // ------------------------------------------------------------------------
    // receiver: stall bursts, none in the calm tail
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            result_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            result_stall = 1'b0;
            if (!calm_tail && $urandom_range(0, 9) == 0)
                hold_left = $urandom_range(1, 14);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(in_loop, loop_ended, report_period, report_iterations);
    end

    // ------------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------------

    // one address item, with an optional idle burst ahead of it
    task automatic send_address(logic [tld_pkg::ADDR_W-1:0] addr);
        int unsigned gap;
        @(negedge clk);
        if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            item_valid   = 1'b0;
            code_segment = tld_pkg::SEG_W'($urandom);
            instr_offset = tld_pkg::SEG_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        code_segment = addr[tld_pkg::ADDR_W-1:tld_pkg::SEG_W];
        instr_offset = addr[tld_pkg::SEG_W-1:0];
        item_valid   = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(addr[tld_pkg::ADDR_W-1:tld_pkg::SEG_W], addr[tld_pkg::SEG_W-1:0]);
        items_sent++;
    endtask

    // pattern repeated for some laps, a partial lap, then a breaking item
    task automatic play_loop(int unsigned period, int unsigned laps,
                             int unsigned tail, bit from_pool);
        logic [tld_pkg::ADDR_W-1:0] pattern [256];
        logic [tld_pkg::ADDR_W-1:0] pool [4];
        foreach (pool[i])
            pool[i] = $urandom;
        for (int unsigned i = 0; i < period; i++)
            pattern[i] = from_pool ? pool[$urandom_range(0, 3)] : $urandom;
        for (int unsigned lap = 0; lap < laps; lap++)
            for (int unsigned i = 0; i < period; i++)
                send_address(pattern[i]);
        for (int unsigned i = 0; i < tail; i++)
            send_address(pattern[i % period]);
        send_address($urandom);
    endtask

    // near miss: the second lap has one bit flipped in one entry
    task automatic play_broken(int unsigned period);
        logic [tld_pkg::ADDR_W-1:0] pattern [256];
        int unsigned                spoil;
        for (int unsigned i = 0; i < period; i++)
            pattern[i] = $urandom;
        for (int unsigned i = 0; i < period; i++)
            send_address(pattern[i]);
        spoil = $urandom_range(0, period - 1);
        pattern[spoil] ^= tld_pkg::ADDR_W'(1) << $urandom_range(0, tld_pkg::ADDR_W - 1);
        for (int unsigned i = 0; i < period; i++)
            send_address(pattern[i]);
    endtask

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned kind;
        bit          wide_done;
        wide_done = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zeroed history: 0000:0000 repeats straight after reset
        repeat (3) send_address(32'h0000_0000);
        // all ones ends that run and starts a period-1 run of its own
        repeat (2) send_address(32'hFFFF_FFFF);
        // alternating bit patterns, period 2
        repeat (4)
        begin
            send_address(32'h5555_AAAA);
            send_address(32'hAAAA_5555);
        end
        send_address(32'h0001_8000);
        send_address(32'h8000_0001);
        // period 3 over three laps, then a break
        repeat (3)
        begin
            send_address(32'h1234_5678);
            send_address(32'h0000_FFFF);
            send_address(32'hFFFF_0000);
        end
        send_address(32'h7FFF_FFFE);

        // random part: mostly well-formed loops with random content
        while (items_sent < 1220)
        begin
            if (items_sent >= 1050)
                calm_tail = 1'b1;
            kind = $urandom_range(0, 99);
            if (!wide_done && items_sent > 200)
            begin
                // widest period the search reaches
                play_loop(255, 2, $urandom_range(0, 20), 1'b0);
                wide_done = 1'b1;
            end
            else if (kind < 3)
                play_loop(1, $urandom_range(30, 200), 0, 1'b0);
            else if (kind < 4)
                play_loop($urandom_range(100, 254), 2, $urandom_range(0, 10), 1'b0);
            else if (kind < 65)
                play_loop(($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8),
                          $urandom_range(1, 6), $urandom_range(0, 7),
                          $urandom_range(0, 3) == 0);
            else if (kind < 80)
                play_broken($urandom_range(1, 12));
            else
                repeat ($urandom_range(1, 10)) send_address($urandom);
        end

        @(negedge clk);
        item_valid = 1'b0;

        // drain, then allow for the pipeline depth
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
sv/tld_pkg.sv
sv/tld_cell.sv
sv/tld_first.sv
sv/tld_divider.sv
sv/trace_loop_detector.sv
sim/trace_loop_detector_tb.sv
